/* sv/vorbis_id_header_parser_defines.svh */
// ---------------------------------------------------------------------------
// Vorbis identification header parser: assertion macros
// Shared macros for the concurrent checks in the parser modules.
// ---------------------------------------------------------------------------
`ifndef VORBIS_ID_HEADER_PARSER_DEFINES_SVH
`define VORBIS_ID_HEADER_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VIHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VIHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/vihp_pkg.sv */
// ---------------------------------------------------------------------------
// Vorbis identification header parser: package
// Transaction types, error codes, byte positions and the magic text.
// ---------------------------------------------------------------------------
package vihp_pkg;

  localparam int BLOCK_W = 14;
  localparam int BLOCK_MIN = 64;
  localparam int BLOCK_MAX = 8192;
  localparam logic [3:0] EXP_MIN = 4'($clog2(BLOCK_MIN));
  localparam logic [3:0] EXP_MAX = 4'($clog2(BLOCK_MAX));

  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_TYPE          = 5'd0;
  localparam logic [POS_W-1:0] POS_MAGIC_LAST    = 5'd6;
  localparam logic [POS_W-1:0] POS_VERSION_LAST  = 5'd10;
  localparam logic [POS_W-1:0] POS_CHANNELS      = 5'd11;
  localparam logic [POS_W-1:0] POS_RATE_LAST     = 5'd15;
  localparam logic [POS_W-1:0] POS_BITRATE_FIRST = 5'd16;
  localparam logic [POS_W-1:0] POS_BITRATE_LAST  = 5'd27;
  localparam logic [POS_W-1:0] POS_BLOCKSIZE     = 5'd28;

  localparam logic [7:0] PACKET_TYPE_ID = 8'h01;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_CHANNELS  = 3'd3,
    ERR_RATE      = 3'd4,
    ERR_BLOCKSIZE = 3'd5,
    ERR_FRAMING   = 3'd6,
    ERR_TRUNCATED = 3'd7
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic       packet_end;
  } in_t;

  typedef struct packed {
    logic [2:0]         error_code;
    logic [7:0]         channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        bitrate_max;
    logic [31:0]        bitrate_target;
    logic [31:0]        bitrate_min;
    logic [BLOCK_W-1:0] block_small;
    logic [BLOCK_W-1:0] block_large;
  } out_t;

  typedef struct packed {
    logic emit;
    out_t data;
  } parse_result_t;

  // The text "vorbis" at positions 1 to 6.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] value;
    case (idx)
      3'd1:    value = 8'h76;
      3'd2:    value = 8'h6F;
      3'd3:    value = 8'h72;
      3'd4:    value = 8'h62;
      3'd5:    value = 8'h69;
      3'd6:    value = 8'h73;
      default: value = 8'h00;
    endcase
    return value;
  endfunction

endpackage

/* sv/vorbis_id_header_parser.sv */
// ---------------------------------------------------------------------------
// Vorbis identification header parser
// Takes one byte of an identification header packet per transaction and
// returns at most one result transaction per packet: an error code on the
// first failing check (type byte, "vorbis" magic, zero version, nonzero
// channel count and sample rate, block sizes between 64 and 8192,
// framing bit), a truncation error if the packet ends before its last byte,
// or the decoded fields after byte 29. Throughput is one byte per clock
// cycle; the parser checks a byte and updates its held fields in the cycle
// it is accepted, and a result is queued and appears on the output in the
// next cycle when no earlier result is still waiting. A two-entry
// result queue lets bytes keep flowing while one result waits on a stalled
// consumer; the input stalls only when both queue entries are occupied.
// Bytes outside a packet (no packet_start since the last result) are
// consumed without a result.
// ---------------------------------------------------------------------------
module vorbis_id_header_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  vihp_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_stall,
  output vihp_pkg::out_t result
);

  // An input transaction completes when the byte is offered and the
  // result queue has room for whatever this byte may produce.
  logic                    accept;
  vihp_pkg::parse_result_t parsed;
  logic                    queue_full;

  assign item_stall = queue_full;
  assign accept     = item_valid && !item_stall;

  // Position tracking, field capture and all header checks.
  vihp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (parsed)
  );

  // Results wait here until the consumer takes them.
  vihp_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .wr      (parsed.emit),
    .wr_data (parsed.data),
    .full    (queue_full),
    .valid   (result_valid),
    .stall   (result_stall),
    .data    (result)
  );

endmodule

/* sv/vihp_parse.sv */
// ---------------------------------------------------------------------------
// Vorbis identification header parser: byte parser
// Holds the parse position and captured fields, checks one accepted byte per cycle.
// ---------------------------------------------------------------------------
`include "vorbis_id_header_parser_defines.svh"

module vihp_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  vihp_pkg::in_t          item,
  output vihp_pkg::parse_result_t result
);

  logic [vihp_pkg::POS_W-1:0] byte_position;
  logic                       parse_finished;
  logic [7:0]                 channels_held;
  logic [31:0]                rate_held;
  logic [31:0]                bitrates_held [3];
  logic [3:0]                 exp_small;
  logic [3:0]                 exp_large;

  logic [vihp_pkg::POS_W-1:0] pos_eff;
  logic [vihp_pkg::POS_W-1:0] bitrate_off;
  logic                       active;
  logic                       emit;
  vihp_pkg::err_t             code;
  logic [7:0]                 b;
  logic [3:0]                 b_small;
  logic [3:0]                 b_large;

  assign b           = item.data_byte;
  assign b_small     = b[3:0];
  assign b_large     = b[7:4];
  assign pos_eff     = item.packet_start ? vihp_pkg::POS_TYPE : byte_position;
  assign active      = accept && (item.packet_start || !parse_finished);
  assign bitrate_off = pos_eff - vihp_pkg::POS_BITRATE_FIRST;

  always_comb begin
    emit = 1'b0;
    code = vihp_pkg::ERR_OK;
    if (pos_eff == vihp_pkg::POS_TYPE) begin
      if (b != vihp_pkg::PACKET_TYPE_ID) begin
        emit = 1'b1;
        code = vihp_pkg::ERR_MAGIC;
      end
    end else if (pos_eff <= vihp_pkg::POS_MAGIC_LAST) begin
      if (b != vihp_pkg::magic_byte(pos_eff[2:0])) begin
        emit = 1'b1;
        code = vihp_pkg::ERR_MAGIC;
      end
    end else if (pos_eff <= vihp_pkg::POS_VERSION_LAST) begin
      if (b != 8'd0) begin
        emit = 1'b1;
        code = vihp_pkg::ERR_VERSION;
      end
    end else if (pos_eff == vihp_pkg::POS_CHANNELS) begin
      if (b == 8'd0) begin
        emit = 1'b1;
        code = vihp_pkg::ERR_CHANNELS;
      end
    end else if (pos_eff <= vihp_pkg::POS_RATE_LAST) begin
      // The top byte arrives last, so the whole rate is known here.
      if (pos_eff == vihp_pkg::POS_RATE_LAST && {b, rate_held[23:0]} == 32'd0) begin
        emit = 1'b1;
        code = vihp_pkg::ERR_RATE;
      end
    end else if (pos_eff <= vihp_pkg::POS_BITRATE_LAST) begin
      emit = 1'b0;
    end else if (pos_eff == vihp_pkg::POS_BLOCKSIZE) begin
      if (b_small < vihp_pkg::EXP_MIN || b_small > b_large || b_large > vihp_pkg::EXP_MAX) begin
        emit = 1'b1;
        code = vihp_pkg::ERR_BLOCKSIZE;
      end
    end else begin
      emit = 1'b1;
      code = b[0] ? vihp_pkg::ERR_OK : vihp_pkg::ERR_FRAMING;
    end
    // A packet that ends before the framing byte is truncated, unless this
    // very byte already failed its own check.
    if (!emit && item.packet_end) begin
      emit = 1'b1;
      code = vihp_pkg::ERR_TRUNCATED;
    end
  end

  always_comb begin
    result.emit = active && emit;
    result.data = '0;
    result.data.error_code = code;
    if (code == vihp_pkg::ERR_OK) begin
      result.data.channel_count  = channels_held;
      result.data.sample_rate    = rate_held;
      result.data.bitrate_max    = bitrates_held[0];
      result.data.bitrate_target = bitrates_held[1];
      result.data.bitrate_min    = bitrates_held[2];
      result.data.block_small    = vihp_pkg::BLOCK_W'(1) << exp_small;
      result.data.block_large    = vihp_pkg::BLOCK_W'(1) << exp_large;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      parse_finished <= 1'b1;
    end else if (active) begin
      parse_finished <= emit;
      byte_position  <= emit ? pos_eff : pos_eff + 5'd1;
    end
  end

  // Each field byte is seen once per packet, so a lane load is enough.
  always_ff @(posedge clk) begin
    if (active) begin
      if (pos_eff == vihp_pkg::POS_CHANNELS) begin
        channels_held <= b;
      end
      if (pos_eff > vihp_pkg::POS_CHANNELS && pos_eff <= vihp_pkg::POS_RATE_LAST) begin
        rate_held[pos_eff[1:0]*8 +: 8] <= b;
      end
      if (pos_eff >= vihp_pkg::POS_BITRATE_FIRST && pos_eff <= vihp_pkg::POS_BITRATE_LAST) begin
        bitrates_held[bitrate_off[3:2]][bitrate_off[1:0]*8 +: 8] <= b;
      end
      if (pos_eff == vihp_pkg::POS_BLOCKSIZE) begin
        exp_small <= b_small;
        exp_large <= b_large;
      end
    end
  end

  `VIHP_ASSERT_SAME(a_emit_needs_accept, result.emit, accept, "result without accepted byte")
  `VIHP_ASSERT_NEXT(a_emit_finishes, result.emit, parse_finished, "parse not closed after result")
  `VIHP_ASSERT_NEXT(a_advance, active && !emit, !parse_finished && byte_position == 5'($past(pos_eff) + 5'd1), "position did not advance")

endmodule

/* sv/vihp_out_buf.sv */
// ---------------------------------------------------------------------------
// Vorbis identification header parser: result buffer
// Two-entry queue that decouples the parser from a stalled consumer.
// ---------------------------------------------------------------------------
`include "vorbis_id_header_parser_defines.svh"

module vihp_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  vihp_pkg::out_t wr_data,
  output logic           full,
  output logic           valid,
  input  logic           stall,
  output vihp_pkg::out_t data
);

  vihp_pkg::out_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           rd;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rd    = valid && !stall;
  assign data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  `VIHP_ASSERT_SAME(a_count_range, 1'b1, count <= 2'd2, "result queue count out of range")
  `VIHP_ASSERT_SAME(a_no_overflow, wr, count != 2'd2, "write into full result queue")
  `VIHP_ASSERT_NEXT(a_drain, count == 2'd1 && rd && !wr, count == 2'd0, "queue did not drain")

endmodule
